// ===== rtl/span_record_stream_parser_assert.svh =====
// Assertion macros for the span record stream parser.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef SPAN_RECORD_STREAM_PARSER_ASSERT_SVH
`define SPAN_RECORD_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define SRSP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("span parser assertion failed");

// Check that a condition never holds outside reset
`define SRSP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("span parser forbidden condition seen");

`else

`define SRSP_ASSERT(lbl, prop)
`define SRSP_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/srsp_pkg.sv =====
// ----------------------------------------------------------------------------
// srsp_pkg
// Shared types and constants of the span record stream parser: beat
// payloads, result kinds, header field codes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package srsp_pkg;

	// Capacity limits and defaults
	localparam int NameCapacity    = 64;
	localparam int KeyCapacity     = 32;
	localparam int ValueCapacity   = 64;
	localparam int AnnotationLimit = 16;

	// Queue between front and back (power of two)
	localparam int QueueDepth = 4;

	// Result kinds
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_NAME   = 3'd1;
	localparam logic [2:0] KIND_KEY    = 3'd2;
	localparam logic [2:0] KIND_VALUE  = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;
	localparam logic [2:0] KIND_ERROR  = 3'd5;

	// Header field codes
	localparam logic [2:0] FLD_TRACE    = 3'd0;
	localparam logic [2:0] FLD_SPAN     = 3'd1;
	localparam logic [2:0] FLD_PARENT   = 3'd2;
	localparam logic [2:0] FLD_START    = 3'd3;
	localparam logic [2:0] FLD_DURATION = 3'd4;
	localparam logic [2:0] FLD_SAMPLED  = 3'd5;
	localparam logic [2:0] FLD_NAMELEN  = 3'd6;
	localparam logic [2:0] FLD_COUNT    = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} span_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  field_id;
		logic [63:0] payload;
		logic [3:0]  annotation_index;
		logic [15:0] byte_position;
		logic        keep;
		logic        last_result;
	} span_out_t;

	// One input byte's work: an optional primary result and an optional
	// trailing done or error result
	typedef struct packed {
		logic        prim_valid;
		logic [2:0]  kind;
		logic [2:0]  field_id;
		logic [63:0] payload;
		logic        scale_us;
		logic [3:0]  annotation_index;
		logic [15:0] byte_position;
		logic        keep;
		logic        tail_valid;
		logic        tail_error;
		logic [31:0] consumed;
	} srsp_op_t;

endpackage

`default_nettype wire

// ===== rtl/srsp_front.sv =====
// ----------------------------------------------------------------------------
// srsp_front
// Byte parser. Tracks the record layout one byte per cycle while the queue has
// room, turning each byte into at most one queue entry describing its results.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_front #(
	parameter int ANNOTATION_LIMIT = srsp_pkg::AnnotationLimit
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire srsp_pkg::span_in_t in_data,
	output logic                push,
	output srsp_pkg::srsp_op_t  push_op,
	input  wire                 q_full
);
	import srsp_pkg::*;

	localparam int AW = $clog2(ANNOTATION_LIMIT + 1);

	localparam logic [3:0] PH_HEADER    = 4'd0;
	localparam logic [3:0] PH_NAME      = 4'd1;
	localparam logic [3:0] PH_KEYLEN_HI = 4'd2;
	localparam logic [3:0] PH_KEYLEN_LO = 4'd3;
	localparam logic [3:0] PH_KEY       = 4'd4;
	localparam logic [3:0] PH_VALLEN_HI = 4'd5;
	localparam logic [3:0] PH_VALLEN_LO = 4'd6;
	localparam logic [3:0] PH_VALUE     = 4'd7;
	localparam logic [3:0] PH_WAIT      = 4'd8;

	logic [3:0]    phase_q, phase_d;
	logic [5:0]    hcnt_q, hcnt_d;
	logic [63:0]   asm_q, asm_d, asm_new;
	logic [15:0]   namelen_q, namelen_d;
	logic [15:0]   total_q, total_d;
	logic [AW-1:0] cur_q, cur_d, cur_inc;
	logic [15:0]   rem_q, rem_d;
	logic [15:0]   pos_q, pos_d;
	logic [7:0]    lhb_q, lhb_d;
	logic [31:0]   cnt_q, cnt_d, cnt_inc;
	logic [15:0]   len;
	logic [16:0]   pos_next;
	logic          more_cur, more_inc;
	logic          complete, clear, bad;
	logic          accept;
	srsp_op_t      op;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Annotation bookkeeping
	assign cur_inc  = cur_q + AW'(1);
	assign more_cur = (17'(cur_q) < {1'b0, total_q}) &&
		(17'(cur_q) < 17'(ANNOTATION_LIMIT));
	assign more_inc = (17'(cur_inc) < {1'b0, total_q}) &&
		(17'(cur_inc) < 17'(ANNOTATION_LIMIT));
	assign asm_new  = {asm_q[55:0], in_data.data_byte};
	assign cnt_inc  = cnt_q + 32'd1;
	assign len      = {lhb_q, in_data.data_byte};
	assign pos_next = {1'b0, pos_q} + 17'd1;

	// Next phase and the entry for this byte
	always_comb begin
		phase_d   = phase_q;
		hcnt_d    = hcnt_q;
		asm_d     = asm_q;
		namelen_d = namelen_q;
		total_d   = total_q;
		cur_d     = cur_q;
		rem_d     = rem_q;
		pos_d     = pos_q;
		lhb_d     = lhb_q;
		cnt_d     = cnt_q;
		op        = '0;
		complete  = 1'b0;
		clear     = 1'b0;
		bad       = 1'b0;
		if (phase_q == PH_WAIT) begin
			clear = in_data.end_of_buffer;
		end else begin
			cnt_d = cnt_inc;
			unique case (phase_q)
				PH_HEADER: begin
					asm_d = asm_new;
					op.kind = KIND_HEADER;
					op.payload = asm_new;
					if (hcnt_q[2:0] == 3'd7 && hcnt_q < 6'd32) begin
						op.prim_valid = 1'b1;
						op.field_id = hcnt_q[5:3];
					end else if (hcnt_q == 6'd39) begin
						op.prim_valid = 1'b1;
						op.field_id = FLD_DURATION;
						op.scale_us = 1'b1;
					end else if (hcnt_q == 6'd40) begin
						op.prim_valid = 1'b1;
						op.field_id = FLD_SAMPLED;
						op.payload = {63'd0, |in_data.data_byte};
					end else if (hcnt_q == 6'd43) begin
						op.prim_valid = 1'b1;
						op.field_id = FLD_NAMELEN;
						op.payload = {48'd0, asm_new[15:0]};
						namelen_d = asm_new[15:0];
					end else if (hcnt_q == 6'd45) begin
						op.prim_valid = 1'b1;
						op.field_id = FLD_COUNT;
						op.payload = {48'd0, asm_new[15:0]};
						total_d = asm_new[15:0];
					end
					if (hcnt_q >= 6'd47) begin
						if (namelen_q != 16'd0) begin
							phase_d = PH_NAME;
							rem_d = namelen_q;
							pos_d = 16'd0;
						end else if (more_cur) begin
							phase_d = PH_KEYLEN_HI;
						end else begin
							complete = 1'b1;
						end
					end else begin
						hcnt_d = hcnt_q + 6'd1;
					end
				end
				PH_NAME: begin
					op.prim_valid = 1'b1;
					op.kind = KIND_NAME;
					op.payload = {56'd0, in_data.data_byte};
					op.byte_position = pos_q;
					op.keep = pos_next < 17'(NameCapacity);
					pos_d = pos_next[15:0];
					rem_d = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						if (more_cur) phase_d = PH_KEYLEN_HI;
						else complete = 1'b1;
					end
				end
				PH_KEYLEN_HI: begin
					lhb_d = in_data.data_byte;
					phase_d = PH_KEYLEN_LO;
				end
				PH_VALLEN_HI: begin
					lhb_d = in_data.data_byte;
					phase_d = PH_VALLEN_LO;
				end
				PH_KEYLEN_LO: begin
					if (len != 16'd0) begin
						phase_d = PH_KEY;
						rem_d = len;
						pos_d = 16'd0;
					end else begin
						phase_d = PH_VALLEN_HI;
					end
				end
				PH_KEY: begin
					op.prim_valid = 1'b1;
					op.kind = KIND_KEY;
					op.payload = {56'd0, in_data.data_byte};
					op.annotation_index = 4'(cur_q);
					op.byte_position = pos_q;
					op.keep = pos_next < 17'(KeyCapacity);
					pos_d = pos_next[15:0];
					rem_d = rem_q - 16'd1;
					if (rem_q == 16'd1) phase_d = PH_VALLEN_HI;
				end
				PH_VALLEN_LO: begin
					if (len != 16'd0) begin
						phase_d = PH_VALUE;
						rem_d = len;
						pos_d = 16'd0;
					end else begin
						cur_d = cur_inc;
						if (more_inc) phase_d = PH_KEYLEN_HI;
						else complete = 1'b1;
					end
				end
				PH_VALUE: begin
					op.prim_valid = 1'b1;
					op.kind = KIND_VALUE;
					op.payload = {56'd0, in_data.data_byte};
					op.annotation_index = 4'(cur_q);
					op.byte_position = pos_q;
					op.keep = pos_next < 17'(ValueCapacity);
					pos_d = pos_next[15:0];
					rem_d = rem_q - 16'd1;
					if (rem_q == 16'd1) begin
						cur_d = cur_inc;
						if (more_inc) phase_d = PH_KEYLEN_HI;
						else complete = 1'b1;
					end
				end
				default: begin
					bad = 1'b1;
					clear = 1'b1;
				end
			endcase
			// Close the record on completion or on an early buffer end
			if (!bad) begin
				if (complete) begin
					op.tail_valid = 1'b1;
					op.consumed = cnt_inc;
					if (in_data.end_of_buffer) clear = 1'b1;
					else phase_d = PH_WAIT;
				end else if (in_data.end_of_buffer) begin
					op.tail_valid = 1'b1;
					op.tail_error = 1'b1;
					clear = 1'b1;
				end
			end
		end
		if (clear) begin
			phase_d   = PH_HEADER;
			hcnt_d    = '0;
			asm_d     = '0;
			namelen_d = '0;
			total_d   = '0;
			cur_d     = '0;
			rem_d     = '0;
			pos_d     = '0;
			lhb_d     = '0;
			cnt_d     = '0;
		end
	end

	assign push    = accept && (op.prim_valid || op.tail_valid);
	assign push_op = op;

	// Advance parser state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hcnt_q    <= '0;
			asm_q     <= '0;
			namelen_q <= '0;
			total_q   <= '0;
			cur_q     <= '0;
			rem_q     <= '0;
			pos_q     <= '0;
			lhb_q     <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hcnt_q    <= hcnt_d;
			asm_q     <= asm_d;
			namelen_q <= namelen_d;
			total_q   <= total_d;
			cur_q     <= cur_d;
			rem_q     <= rem_d;
			pos_q     <= pos_d;
			lhb_q     <= lhb_d;
			cnt_q     <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srsp_queue.sv =====
// ----------------------------------------------------------------------------
// srsp_queue
// Small first-in first-out queue of parsed entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "span_record_stream_parser_assert.svh"

module srsp_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire srsp_pkg::srsp_op_t push_op,
	output logic                full,
	input  wire                 pop,
	output logic                head_valid,
	output srsp_pkg::srsp_op_t  head_op
);
	import srsp_pkg::*;

	localparam int PW = $clog2(QueueDepth);

	srsp_op_t       mem_q [QueueDepth];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW:0]    count_q;

	assign full       = count_q == (PW + 1)'(QueueDepth);
	assign head_valid = count_q != '0;
	assign head_op    = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_op;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + (PW + 1)'(1);
			else if (pop && !push) count_q <= count_q - (PW + 1)'(1);
		end
	end

	`SRSP_NEVER(a_push_full, push && full)
	`SRSP_NEVER(a_pop_empty, pop && !head_valid)
	`SRSP_NEVER(a_count_range, count_q > (PW + 1)'(QueueDepth))
	`SRSP_ASSERT(a_push_nonempty, push |-> (push_op.prim_valid || push_op.tail_valid))

endmodule

`default_nettype wire

// ===== rtl/srsp_back.sv =====
// ----------------------------------------------------------------------------
// srsp_back
// Result issue. Expands each queue entry into one or two result beats and
// holds them in the output register; scales the duration to nanoseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  wire srsp_pkg::srsp_op_t head_op,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output srsp_pkg::span_out_t out_data
);
	import srsp_pkg::*;

	logic        out_valid_q;
	span_out_t   out_q, out_d;
	logic        second_q, second_d;
	logic        load;
	logic [63:0] scaled;

	// Times 1000 as 1024 - 32 + 8
	assign scaled = (head_op.payload << 10) - (head_op.payload << 5) +
		(head_op.payload << 3);

	// Pick the next beat from the head entry
	always_comb begin
		out_d    = '0;
		pop      = 1'b0;
		load     = 1'b0;
		second_d = second_q;
		if (head_valid && (!out_valid_q || out_ready)) begin
			load = 1'b1;
			if (head_op.prim_valid && !second_q) begin
				out_d.kind             = head_op.kind;
				out_d.field_id         = head_op.field_id;
				out_d.payload          = head_op.scale_us ? scaled : head_op.payload;
				out_d.annotation_index = head_op.annotation_index;
				out_d.byte_position    = head_op.byte_position;
				out_d.keep             = head_op.keep;
				out_d.last_result      = !head_op.tail_valid;
				if (head_op.tail_valid) second_d = 1'b1;
				else pop = 1'b1;
			end else begin
				out_d.kind        = head_op.tail_error ? KIND_ERROR : KIND_DONE;
				out_d.payload     = head_op.tail_error ? 64'd0 : {32'd0, head_op.consumed};
				out_d.last_result = 1'b1;
				pop               = 1'b1;
				second_d          = 1'b0;
			end
		end
	end

	// Hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			second_q <= second_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/span_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// span_record_stream_parser
// Parses a span record byte stream into header fields, string bytes and a
// done or error marker.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | srsp_pkg::span_in_t
//   out     | output    | out_valid / out_ready  | srsp_pkg::span_out_t
//
// One byte is accepted per cycle while the four-entry queue has room.
// A byte yields zero, one or two results; the output register issues one
// result per cycle while out_ready is high, so a byte with a header field or
// string byte plus done or error takes two output beats.
// First result is registered in the queue and then in the output register.
// Reset clears parser state and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module span_record_stream_parser #(
	parameter int ANNOTATION_LIMIT = srsp_pkg::AnnotationLimit
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire srsp_pkg::span_in_t in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output srsp_pkg::span_out_t out_data
);
	import srsp_pkg::*;

	logic      push, pop, q_full, head_valid;
	srsp_op_t  push_op, head_op;

	srsp_front #(
		.ANNOTATION_LIMIT(ANNOTATION_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_op  (push_op),
		.q_full   (q_full)
	);

	srsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	srsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire
